[rtl/core/three_phase_power_calc_assert.svh]
// Assertion macros for the three phase power calculator.
`ifndef THREE_PHASE_POWER_CALC_ASSERT_SVH
`define THREE_PHASE_POWER_CALC_ASSERT_SVH
`ifndef SYNTHESIS
`define TPPC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tppc: same cycle check failed");
`define TPPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tppc: next cycle check failed");
`else
`define TPPC_ASSERT_IMPLY(label, ante, cons)
`define TPPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/tppc_pkg.sv]
package tppc_pkg;

   localparam int NSTAGE          = 24;
   localparam int CORE_FIRST      = 7;
   localparam int CORE_STAGES     = 14;
   localparam int STEPS_PER_STAGE = 3;
   localparam int ROOT_STEPS      = 40;
   localparam int QF_STEPS        = 17;
   localparam int DIV_STEPS       = 15;

   localparam int V_W    = 19;
   localparam int I_W    = 16;
   localparam int PF_W   = 17;
   localparam int VS_W   = 21;
   localparam int IS_W   = 18;
   localparam int M_W    = 39;
   localparam int SQ_W   = 80;
   localparam int ROOT_W = 41;
   localparam int REM_W  = 44;
   localparam int NUM_W  = 36;
   localparam int UNB_W  = 15;
   localparam int MV_W   = 23;
   localparam int MI_W   = 19;
   localparam int POW_W  = 29;
   localparam int IN_W   = 128;
   localparam int OUT_W  = 176;

   localparam logic [PF_W-1:0] PF_ONE      = 17'd65536;
   localparam logic [25:0]     RECIP3      = 26'd44739243;
   localparam logic [13:0]     UNB_SCALE   = 14'd10000;
   localparam logic [27:0]     RECIP625    = 28'd219902326;
   localparam logic [19:0]     RECIP900_HI = 20'd596524;
   localparam logic [30:0]     RECIP900_LO = 31'd1221679587;
   localparam logic [18:0]     POW_DIV     = 19'd900;
   localparam logic [41:0]     POW_SAT     = 42'd483183820800;
   localparam logic [17:0]     EST_CLIP    = 18'd29491;
   localparam logic [16:0]     EST_BASE    = 17'd62259;
   localparam logic [16:0]     EST_MIN     = 17'd32768;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] q;
      logic [SQ_W-1:0]   rad;
   } root_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [UNB_W-1:0] q;
   } div_type;

   typedef struct packed {
      root_type        r;
      root_type        f;
      div_type         v;
      div_type         i;
      logic [VS_W-1:0] vdiv;
      logic [VS_W-1:0] idiv;
   } core_type;

   typedef struct packed {
      logic [MV_W-1:0] meanv;
      logic [MI_W-1:0] meani;
      logic            vzero;
      logic            izero;
      logic [PF_W-1:0] pfc;
   } side_type;

   typedef struct packed {
      logic [PF_W-1:0]  est;
      logic [POW_W-1:0] reactive;
      logic [POW_W-1:0] active;
      logic [POW_W-1:0] apparent;
      logic [UNB_W-1:0] cu;
      logic [UNB_W-1:0] vu;
      logic [MI_W-1:0]  mi;
      logic [MV_W-1:0]  mv;
   } out_type;

   function automatic root_type root_step(root_type a);
      root_type         r;
      logic [REM_W-1:0] t;
      logic [REM_W-1:0] trial;
      t     = {a.rem[REM_W-3:0], a.rad[SQ_W-1 -: 2]};
      trial = {1'b0, a.q, 2'b01};
      r.rad = {a.rad[SQ_W-3:0], 2'b00};
      if (t >= trial) begin
         r.rem = t - trial;
         r.q   = {a.q[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem = t;
         r.q   = {a.q[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic div_type div_step(div_type a, logic [VS_W-1:0] d, int j);
      div_type          r;
      logic [NUM_W-1:0] trial;
      trial = {{(NUM_W-VS_W){1'b0}}, d} << j;
      if (a.rem >= trial) begin
         r.rem = a.rem - trial;
         r.q   = {a.q[UNB_W-2:0], 1'b1};
      end else begin
         r.rem = a.rem;
         r.q   = {a.q[UNB_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

[rtl/core/tppc_core.sv]
module tppc_core import tppc_pkg::*; (
   input  logic                   clock,
   input  logic [CORE_STAGES-1:0] core_en,
   input  core_type               core_in,
   output core_type               core_out
);

   core_type stage_src [CORE_STAGES];
   core_type stage_in  [CORE_STAGES];
   core_type stage_ff  [CORE_STAGES];

   for (genvar c = 0; c < CORE_STAGES; c++) begin : g_stage
      if (c == 0) begin : g_first
         assign stage_src[c] = core_in;
      end else begin : g_next
         assign stage_src[c] = stage_ff[c-1];
      end

      always_comb begin
         core_type step_x;
         step_x = stage_src[c];
         for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            if (c * STEPS_PER_STAGE + i < ROOT_STEPS) begin
               step_x.r = root_step(step_x.r);
            end
            if (c * STEPS_PER_STAGE + i < QF_STEPS) begin
               step_x.f = root_step(step_x.f);
            end
            if (c * STEPS_PER_STAGE + i < DIV_STEPS) begin
               step_x.v = div_step(step_x.v, step_x.vdiv,
                                   DIV_STEPS - 1 - (c * STEPS_PER_STAGE + i));
               step_x.i = div_step(step_x.i, step_x.idiv,
                                   DIV_STEPS - 1 - (c * STEPS_PER_STAGE + i));
            end
         end
         stage_in[c] = step_x;
      end

      always_ff @(posedge clock) begin
         if (core_en[c]) begin
            stage_ff[c] <= stage_in[c];
         end
      end
   end

   assign core_out = stage_ff[CORE_STAGES-1];

endmodule

[rtl/core/three_phase_power_calc.sv]
// Three phase power calculator: every item carries three phase voltages, three phase currents
// and a power factor, and yields one result item with the mean voltage and current, their
// unbalance, apparent, active and reactive power and a power factor estimated from the
// unbalance. The block takes one item in every cycle while req_tready is high. The power result comes
// from the square root of three times the 80 bit squared power, which resolves up to three root
// bits in each of fourteen stages; every stage holds its item only while the stage after it is
// full, so a waiting result stops new items from entering only once every stage is full.
`include "three_phase_power_calc_assert.svh"

module three_phase_power_calc import tppc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // voltage_a, voltage_b, voltage_c, current_a, current_b, current_c, power_factor, zeros
   input  logic [IN_W-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // mean_voltage, mean_current, voltage_unbalance, current_unbalance, apparent_power,
   // active_power, reactive_power, estimated_pf
   output logic [OUT_W-1:0] rsp_tdata
);

   typedef struct packed {
      logic [PF_W-1:0] pf;
      logic [I_W-1:0]  ic;
      logic [I_W-1:0]  ib;
      logic [I_W-1:0]  ia;
      logic [V_W-1:0]  vc;
      logic [V_W-1:0]  vb;
      logic [V_W-1:0]  va;
   } s1_type;

   typedef struct packed {
      logic [VS_W-1:0] vs;
      logic [IS_W-1:0] is;
      logic [PF_W-1:0] pfc;
      logic [V_W-1:0]  va;
      logic [V_W-1:0]  vb;
      logic [V_W-1:0]  vc;
      logic [I_W-1:0]  ia;
      logic [I_W-1:0]  ib;
      logic [I_W-1:0]  ic;
   } s2_type;

   typedef struct packed {
      logic [M_W-1:0]  m;
      logic [VS_W-1:0] dv;
      logic [IS_W-1:0] di;
      logic [MV_W-1:0] meanv;
      logic [19:0]     meani;
      logic [VS_W-1:0] vs;
      logic [IS_W-1:0] is;
      logic [PF_W-1:0] pfc;
      logic [32:0]     pfsq;
   } s3_type;

   typedef struct packed {
      logic [39:0]      hh;
      logic [38:0]      hl;
      logic [37:0]      ll;
      logic [NUM_W-1:0] nv;
      logic [NUM_W-1:0] ni;
      logic [32:0]      qrad;
      logic [VS_W-1:0]  vs;
      logic [IS_W-1:0]  is;
      side_type         side;
   } s4_type;

   typedef struct packed {
      logic [77:0]      sq;
      logic [NUM_W-1:0] nv;
      logic [NUM_W-1:0] ni;
      logic [32:0]      qrad;
      logic [VS_W-1:0]  vs;
      logic [IS_W-1:0]  is;
      side_type         side;
   } s5_type;

   typedef struct packed {
      logic [SQ_W-1:0]  r3;
      logic [NUM_W-1:0] nv;
      logic [NUM_W-1:0] ni;
      logic [32:0]      qrad;
      logic [VS_W-1:0]  vs;
      logic [IS_W-1:0]  is;
      side_type         side;
   } s6_type;

   typedef struct packed {
      logic [MV_W-1:0]  meanv;
      logic [MI_W-1:0]  meani;
      logic [UNB_W-1:0] uv;
      logic [UNB_W-1:0] ui;
      logic [PF_W-1:0]  est;
   } tail_type;

   typedef struct packed {
      logic [ROOT_W-1:0] r;
      logic [57:0]       pr;
      logic [57:0]       qr;
      logic [17:0]       eq;
      tail_type          tail;
   } s21_type;

   typedef struct packed {
      logic        sat;
      logic [18:0] yh;
      logic [19:0] yl;
      logic [9:0]  qh;
   } lane_type;

   typedef struct packed {
      lane_type [2:0] lane;
      tail_type       tail;
   } s22_type;

   typedef struct packed {
      logic        sat;
      logic [9:0]  qh;
      logic [29:0] x2;
   } lane2_type;

   typedef struct packed {
      lane2_type [2:0] lane;
      tail_type        tail;
   } s23_type;

   logic [NSTAGE:1]   valid_ff;
   logic [NSTAGE:1]   valid_in;
   logic [NSTAGE:1]   valid_prev;
   logic [NSTAGE+1:1] stage_en;

   s1_type   s1_in,  s1_ff;
   s2_type   s2_in,  s2_ff;
   s3_type   s3_in,  s3_ff;
   s4_type   s4_in,  s4_ff;
   s5_type   s5_in,  s5_ff;
   s6_type   s6_in,  s6_ff;
   s21_type  s21_in, s21_ff;
   s22_type  s22_in, s22_ff;
   s23_type  s23_in, s23_ff;
   out_type  out_in, out_ff;
   side_type side_dly_ff [CORE_STAGES];
   core_type core_in, core_out;

   function automatic logic [VS_W-1:0] dev3(logic [VS_W-1:0] x, logic [VS_W-1:0] s);
      logic [VS_W-1:0] t;
      t = x + {x[VS_W-2:0], 1'b0};
      return (t >= s) ? t - s : s - t;
   endfunction

   function automatic logic [VS_W-1:0] max3(logic [VS_W-1:0] a, logic [VS_W-1:0] b,
                                            logic [VS_W-1:0] c);
      logic [VS_W-1:0] m;
      m = (a > b) ? a : b;
      return (c > m) ? c : m;
   endfunction

   // Handshake and stage advance.
   always_comb begin
      stage_en[NSTAGE+1] = rsp_tready;
      for (int k = NSTAGE; k >= 1; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign valid_prev = {valid_ff[NSTAGE-1:1], req_tvalid};

   always_comb begin
      for (int k = 1; k <= NSTAGE; k++) begin
         valid_in[k] = stage_en[k] ? valid_prev[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_en[1];
   assign rsp_tvalid = valid_ff[NSTAGE];
   assign rsp_tdata  = out_ff;

   // Stage 1: capture.
   assign s1_in = req_tdata[$bits(s1_type)-1:0];

   // Stage 2: phase sums and clamped power factor.
   always_comb begin
      s2_in.vs  = {2'b00, s1_ff.va} + {2'b00, s1_ff.vb} + {2'b00, s1_ff.vc};
      s2_in.is  = {2'b00, s1_ff.ia} + {2'b00, s1_ff.ib} + {2'b00, s1_ff.ic};
      s2_in.pfc = (s1_ff.pf > PF_ONE) ? PF_ONE : s1_ff.pf;
      s2_in.va  = s1_ff.va;
      s2_in.vb  = s1_ff.vb;
      s2_in.vc  = s1_ff.vc;
      s2_in.ia  = s1_ff.ia;
      s2_in.ib  = s1_ff.ib;
      s2_in.ic  = s1_ff.ic;
   end

   // Stage 3: product of sums, largest deviations, means and power factor square.
   always_comb begin
      logic [24:0]     v10;
      logic [21:0]     i10;
      logic [50:0]     vp;
      logic [47:0]     ip;
      logic [VS_W-1:0] isx;
      logic [VS_W-1:0] di;
      v10   = {1'b0, s2_ff.vs, 3'b000} + {3'b000, s2_ff.vs, 1'b0};
      i10   = {1'b0, s2_ff.is, 3'b000} + {3'b000, s2_ff.is, 1'b0};
      vp    = 51'(v10) * 51'(RECIP3);
      ip    = 48'(i10) * 48'(RECIP3);
      isx   = {3'b000, s2_ff.is};
      di    = max3(dev3({5'd0, s2_ff.ia}, isx), dev3({5'd0, s2_ff.ib}, isx),
                   dev3({5'd0, s2_ff.ic}, isx));
      s3_in.m     = M_W'(s2_ff.vs) * M_W'(s2_ff.is);
      s3_in.dv    = max3(dev3({2'b00, s2_ff.va}, s2_ff.vs), dev3({2'b00, s2_ff.vb}, s2_ff.vs),
                         dev3({2'b00, s2_ff.vc}, s2_ff.vs));
      s3_in.di    = di[IS_W-1:0];
      s3_in.meanv = vp[49:27];
      s3_in.meani = ip[46:27];
      s3_in.vs    = s2_ff.vs;
      s3_in.is    = s2_ff.is;
      s3_in.pfc   = s2_ff.pfc;
      s3_in.pfsq  = 33'(s2_ff.pfc) * 33'(s2_ff.pfc);
   end

   // Stage 4: partial products of the squared power and the unbalance numerators.
   always_comb begin
      s4_in.hh         = 40'(s3_ff.m[M_W-1:19]) * 40'(s3_ff.m[M_W-1:19]);
      s4_in.hl         = 39'(s3_ff.m[M_W-1:19]) * 39'(s3_ff.m[18:0]);
      s4_in.ll         = 38'(s3_ff.m[18:0]) * 38'(s3_ff.m[18:0]);
      s4_in.nv         = NUM_W'(s3_ff.dv) * NUM_W'(UNB_SCALE);
      s4_in.ni         = NUM_W'(s3_ff.di) * NUM_W'(UNB_SCALE);
      s4_in.qrad       = 33'h1_0000_0000 - s3_ff.pfsq;
      s4_in.vs         = s3_ff.vs;
      s4_in.is         = s3_ff.is;
      s4_in.side.meanv = s3_ff.meanv;
      s4_in.side.meani = s3_ff.meani[19] ? '1 : s3_ff.meani[MI_W-1:0];
      s4_in.side.vzero = (s3_ff.vs == '0);
      s4_in.side.izero = (s3_ff.is == '0);
      s4_in.side.pfc   = s3_ff.pfc;
   end

   // Stage 5: squared power.
   always_comb begin
      s5_in.sq   = {s4_ff.hh, 38'd0} + 78'({s4_ff.hl, 20'd0}) + 78'(s4_ff.ll);
      s5_in.nv   = s4_ff.nv;
      s5_in.ni   = s4_ff.ni;
      s5_in.qrad = s4_ff.qrad;
      s5_in.vs   = s4_ff.vs;
      s5_in.is   = s4_ff.is;
      s5_in.side = s4_ff.side;
   end

   // Stage 6: three times the squared power.
   always_comb begin
      s6_in.r3   = 80'({s5_ff.sq, 1'b0}) + 80'(s5_ff.sq);
      s6_in.nv   = s5_ff.nv;
      s6_in.ni   = s5_ff.ni;
      s6_in.qrad = s5_ff.qrad;
      s6_in.vs   = s5_ff.vs;
      s6_in.is   = s5_ff.is;
      s6_in.side = s5_ff.side;
   end

   always_comb begin
      core_in.r.rem = '0;
      core_in.r.q   = '0;
      core_in.r.rad = s6_ff.r3;
      core_in.f.rem = '0;
      core_in.f.q   = '0;
      core_in.f.rad = {1'b0, s6_ff.qrad, 46'd0};
      core_in.v.rem = s6_ff.nv;
      core_in.v.q   = '0;
      core_in.i.rem = s6_ff.ni;
      core_in.i.q   = '0;
      core_in.vdiv  = s6_ff.vs;
      core_in.idiv  = {3'b000, s6_ff.is};
   end

   tppc_core u_core (
      .clock    (clock),
      .core_en  (stage_en[CORE_FIRST+CORE_STAGES-1:CORE_FIRST]),
      .core_in  (core_in),
      .core_out (core_out)
   );

   for (genvar c = 0; c < CORE_STAGES; c++) begin : g_side
      if (c == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (stage_en[CORE_FIRST]) begin
               side_dly_ff[c] <= s6_ff.side;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (stage_en[CORE_FIRST+c]) begin
               side_dly_ff[c] <= side_dly_ff[c-1];
            end
         end
      end
   end

   // Stage 21: power products and the unbalance sum scaled for the estimate.
   always_comb begin
      side_type    sd;
      logic [15:0] esum;
      logic [54:0] ep;
      sd   = side_dly_ff[CORE_STAGES-1];
      s21_in.tail.meanv = sd.meanv;
      s21_in.tail.meani = sd.meani;
      s21_in.tail.uv    = sd.vzero ? '0 : core_out.v.q;
      s21_in.tail.ui    = sd.izero ? '0 : core_out.i.q;
      s21_in.tail.est   = '0;
      esum = {1'b0, s21_in.tail.uv} + {1'b0, s21_in.tail.ui};
      ep   = 55'({esum, 11'd0}) * 55'(RECIP625);
      s21_in.eq = ep[54:37];
      s21_in.r  = core_out.r.q;
      s21_in.pr = 58'(core_out.r.q) * 58'(sd.pfc);
      s21_in.qr = 58'(core_out.r.q) * 58'(core_out.f.q[PF_W-1:0]);
   end

   // Stage 22: saturation check, the upper quotient digits of the divide by 900 and the estimate.
   always_comb begin
      logic [41:0] y [3];
      logic [38:0] hp;
      y[0] = {1'b0, s21_ff.r};
      y[1] = s21_ff.pr[57:16];
      y[2] = s21_ff.qr[57:16];
      for (int n = 0; n < 3; n++) begin
         hp = 39'(y[n][38:20]) * 39'(RECIP900_HI);
         s22_in.lane[n].sat = (y[n] >= POW_SAT);
         s22_in.lane[n].yh  = y[n][38:20];
         s22_in.lane[n].yl  = y[n][19:0];
         s22_in.lane[n].qh  = hp[38:29];
      end
      s22_in.tail     = s21_ff.tail;
      s22_in.tail.est = (s21_ff.eq >= EST_CLIP) ? EST_MIN : EST_BASE - s21_ff.eq[PF_W-1:0];
   end

   // Stage 23: remainder of the upper digits joined to the lower bits.
   always_comb begin
      logic [18:0] diff;
      for (int n = 0; n < 3; n++) begin
         diff = s22_ff.lane[n].yh - {9'd0, s22_ff.lane[n].qh} * POW_DIV;
         s23_in.lane[n].sat = s22_ff.lane[n].sat;
         s23_in.lane[n].qh  = s22_ff.lane[n].qh;
         s23_in.lane[n].x2  = {diff[9:0], s22_ff.lane[n].yl};
      end
      s23_in.tail = s22_ff.tail;
   end

   // Stage 24: lower quotient digits and the result item.
   always_comb begin
      logic [60:0]      lp;
      logic [POW_W-1:0] pw [3];
      for (int n = 0; n < 3; n++) begin
         lp    = 61'(s23_ff.lane[n].x2) * 61'(RECIP900_LO);
         pw[n] = s23_ff.lane[n].sat ? '1 : {s23_ff.lane[n].qh[8:0], lp[59:40]};
      end
      out_in.mv       = s23_ff.tail.meanv;
      out_in.mi       = s23_ff.tail.meani;
      out_in.vu       = s23_ff.tail.uv;
      out_in.cu       = s23_ff.tail.ui;
      out_in.apparent = pw[0];
      out_in.active   = pw[1];
      out_in.reactive = pw[2];
      out_in.est      = s23_ff.tail.est;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_ff <= s1_in;
      end
      if (stage_en[2]) begin
         s2_ff <= s2_in;
      end
      if (stage_en[3]) begin
         s3_ff <= s3_in;
      end
      if (stage_en[4]) begin
         s4_ff <= s4_in;
      end
      if (stage_en[5]) begin
         s5_ff <= s5_in;
      end
      if (stage_en[6]) begin
         s6_ff <= s6_in;
      end
      if (stage_en[21]) begin
         s21_ff <= s21_in;
      end
      if (stage_en[22]) begin
         s22_ff <= s22_in;
      end
      if (stage_en[23]) begin
         s23_ff <= s23_in;
      end
      if (stage_en[24]) begin
         out_ff <= out_in;
      end
   end

   `TPPC_ASSERT_IMPLY(a_blocked_means_full, !req_tready, &valid_ff)
   `TPPC_ASSERT_NEXT(a_capture, req_tvalid && req_tready, valid_ff[1])
   `TPPC_ASSERT_IMPLY(a_est_range, rsp_tvalid, (out_ff.est >= EST_MIN) && (out_ff.est <= PF_ONE))
   `TPPC_ASSERT_IMPLY(a_power_order, rsp_tvalid,
      (out_ff.active <= out_ff.apparent) && (out_ff.reactive <= out_ff.apparent))

endmodule

[bench/three_phase_power_calc_tb.sv]
`timescale 1ns / 100ps

module three_phase_power_calc_tb import tppc_pkg::*; ();

   typedef struct packed {
      logic [16:0] pf;
      logic [15:0] ic;
      logic [15:0] ib;
      logic [15:0] ia;
      logic [18:0] vc;
      logic [18:0] vb;
      logic [18:0] va;
   } meas_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;

   out_type expected_results[$];
   int errors = 0;
   bit idle_on = 1'b1;
   bit hold_off = 1'b0;

   three_phase_power_calc u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [63:0] floor_root(logic [127:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= x) r = c;
      end
      return r;
   endfunction

   function automatic logic [63:0] spread(logic [63:0] a, logic [63:0] b, logic [63:0] c);
      logic [63:0] s;
      logic [63:0] best;
      logic [63:0] t;
      logic [63:0] d;
      logic [63:0] x[3];
      s = a + b + c;
      best = 0;
      x[0] = a; x[1] = b; x[2] = c;
      if (s == 0) return 0;
      for (int i = 0; i < 3; i++) begin
         t = 3 * x[i];
         d = (t >= s) ? t - s : s - t;
         if (d > best) best = d;
      end
      return best * 10000 / s;
   endfunction

   function automatic logic [63:0] clip(logic [127:0] v, int w);
      logic [127:0] m;
      m = (128'd1 << w) - 1;
      return (v > m) ? m[63:0] : v[63:0];
   endfunction

   function automatic out_type power_figures(meas_type m);
      out_type o;
      logic [63:0] vs;
      logic [63:0] is;
      logic [63:0] uv;
      logic [63:0] ui;
      logic [63:0] r;
      logic [63:0] qf;
      logic [63:0] pf;
      logic [127:0] p;
      longint est;
      vs = 64'(m.va) + 64'(m.vb) + 64'(m.vc);
      is = 64'(m.ia) + 64'(m.ib) + 64'(m.ic);
      uv = spread(64'(m.va), 64'(m.vb), 64'(m.vc));
      ui = spread(64'(m.ia), 64'(m.ib), 64'(m.ic));
      p = {64'd0, vs * is};
      r = floor_root(3 * p * p);
      pf = (m.pf > 65536) ? 64'd65536 : 64'(m.pf);
      qf = floor_root((128'd1 << 32) - 128'(pf * pf));
      est = 62259 - longint'((uv + ui) * 65536 / 20000);
      if (est < 32768) est = 32768;
      if (est > 65536) est = 65536;
      o.mv = MV_W'(clip(128'(vs * 10 / 3), 23));
      o.mi = MI_W'(clip(128'(is * 10 / 3), 19));
      o.vu = UNB_W'(clip(128'(uv), 15));
      o.cu = UNB_W'(clip(128'(ui), 15));
      o.apparent = POW_W'(clip(128'(r / 900), 29));
      o.active = POW_W'(clip({64'd0, r} * {64'd0, pf} / (900 * 65536), 29));
      o.reactive = POW_W'(clip({64'd0, r} * {64'd0, qf} / (900 * 65536), 29));
      o.est = est[16:0];
      return o;
   endfunction

   task automatic send_item(meas_type m);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(IN_W - $bits(meas_type)){1'b0}}, m};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(power_figures(m));
   endtask

   // The receiver stalls in bursts, or for a long stretch when asked to.
   initial begin
      int gap;
      gap = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
            rsp_tready <= 1'b1;
         end else if (gap > 0) begin
            gap--;
            rsp_tready <= (gap == 0);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      out_type got;
      out_type exp_o;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_results.size() == 0) begin
            $error("unexpected result item");
            errors++;
         end else begin
            exp_o = expected_results.pop_front();
            if (got.mv !== exp_o.mv) begin
               $error("mean_voltage exp %0d got %0d", exp_o.mv, got.mv); errors++;
            end
            if (got.mi !== exp_o.mi) begin
               $error("mean_current exp %0d got %0d", exp_o.mi, got.mi); errors++;
            end
            if (got.vu !== exp_o.vu) begin
               $error("voltage_unbalance exp %0d got %0d", exp_o.vu, got.vu); errors++;
            end
            if (got.cu !== exp_o.cu) begin
               $error("current_unbalance exp %0d got %0d", exp_o.cu, got.cu); errors++;
            end
            if (got.apparent !== exp_o.apparent) begin
               $error("apparent_power exp %0d got %0d", exp_o.apparent, got.apparent);
               errors++;
            end
            if (got.active !== exp_o.active) begin
               $error("active_power exp %0d got %0d", exp_o.active, got.active); errors++;
            end
            if (got.reactive !== exp_o.reactive) begin
               $error("reactive_power exp %0d got %0d", exp_o.reactive, got.reactive);
               errors++;
            end
            if (got.est !== exp_o.est) begin
               $error("estimated_pf exp %0d got %0d", exp_o.est, got.est); errors++;
            end
         end
      end
   end

   function automatic meas_type random_set(bit full);
      meas_type m;
      logic [127:0] raw;
      int base;
      if (full) begin
         raw = {$urandom, $urandom, $urandom, $urandom};
         m = raw[$bits(meas_type)-1:0];
      end else begin
         base = $urandom_range(0, 500000);
         m.va = V_W'((base + $urandom_range(0, 20000)) % 500001);
         m.vb = V_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 500000) : base);
         m.vc = V_W'($urandom_range(0, 500000));
         m.ia = I_W'($urandom_range(0, 50000));
         m.ib = $urandom_range(0, 1) ? m.ia : I_W'($urandom_range(0, 50000));
         m.ic = I_W'($urandom_range(0, 50000));
         m.pf = PF_W'($urandom_range(6554, 65536));
      end
      return m;
   endfunction

   task automatic test_corners();
      meas_type m;
      m = '0; m.pf = 65536; send_item(m);
      m = '0; m.pf = 6554; send_item(m);
      m = '1; send_item(m);
      m = '0; m.va = 500000; m.vb = 500000; m.vc = 500000;
      m.ia = 50000; m.ib = 50000; m.ic = 50000; m.pf = 65536; send_item(m);
      m.pf = 6554; send_item(m);
      m.pf = 100000; send_item(m);
      m.pf = 65537; send_item(m);
      m.vb = 0; m.vc = 0; m.ib = 0; m.ic = 0; m.pf = 40000; send_item(m);
      m = '0; m.va = 1; m.ia = 1; m.pf = 32768; send_item(m);
      m = '0; m.vc = 500000; m.ic = 50000; m.pf = 50000; send_item(m);
      m = '1; m.pf = 65536; send_item(m);
      m = '0; m.va = 230; m.vb = 231; m.vc = 229; m.ia = 10; m.ib = 10; m.ic = 11;
      m.pf = 60000; send_item(m);
      m = '0; m.va = 100; m.vb = 100; m.vc = 100; m.pf = 1; send_item(m);
   endtask

   task automatic test_random(int n);
      for (int k = 0; k < n; k++) send_item(random_set($urandom_range(0, 9) == 0));
   endtask

   task automatic test_back_pressure();
      hold_off = 1'b1;
      test_random(80);
   endtask

   task automatic test_full_rate();
      idle_on = 1'b0;
      test_random(200);
   endtask

   initial begin
      int waited;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_corners();
      test_random(500);
      test_back_pressure();
      test_random(500);
      test_full_rate();
      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_results.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
